### src/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg
// shared types, arctangent table and register map for the go-to-goal block
// ----------------------------------------------------------------------------
package gtg_pkg;

    localparam int XW   = 34;   // cordic x/y width: 17 bit diff << 14, plus growth
    localparam int ZW   = 33;   // angle accumulator, Q.30 signed
    localparam int SQW  = 35;   // dx^2 + dy^2
    localparam int RTW  = 18;   // root width
    localparam int SQRT_STEPS = 18;
    localparam int MAX_STAGES = 24;

    localparam logic [2:0] REG_LIN_GAIN = 3'd0;
    localparam logic [2:0] REG_ANG_GAIN = 3'd1;
    localparam logic [2:0] REG_MAX_LIN  = 3'd2;
    localparam logic [2:0] REG_MAX_ANG  = 3'd3;
    localparam logic [2:0] REG_STOP     = 3'd4;

    localparam logic signed [ZW-1:0] HALF_PI = 33'sd1686629713;

    typedef struct packed {
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
        logic signed [ZW-1:0]  z;
        logic [SQW-1:0]        rem;
        logic [RTW-1:0]        root;
        logic signed [14:0]    hd;
        logic                  zero;
    } t_cell;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic [31:0] v;
        begin
            unique case (i)
                0:  v = 32'h3243F6A8;  1:  v = 32'h1DAC6705;  2:  v = 32'h0FADBAFC;
                3:  v = 32'h07F56EA6;  4:  v = 32'h03FEAB76;  5:  v = 32'h01FFD55B;
                6:  v = 32'h00FFFAAA;  7:  v = 32'h007FFF55;  8:  v = 32'h003FFFEA;
                9:  v = 32'h001FFFFD;  10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
                12: v = 32'h0003FFFF;  13: v = 32'h0001FFFF;  14: v = 32'h0000FFFF;
                15: v = 32'h00007FFF;  16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
                18: v = 32'h00000FFF;  19: v = 32'h000007FF;  20: v = 32'h000003FF;
                21: v = 32'h000001FF;  22: v = 32'h000000FF;  23: v = 32'h0000007F;
                default: v = 32'h0;
            endcase
            atan_entry = signed'({1'b0, v});
        end
    endfunction

endpackage

### src/gtg_cell.sv
// ----------------------------------------------------------------------------
// gtg_cell
// one pipeline cell: a cordic vectoring step and a square root digit step
// ----------------------------------------------------------------------------
module gtg_cell #(
    parameter int CORDIC_IDX = 0,   // -1 skips the cordic step
    parameter int SQRT_IDX   = 0    // -1 skips the root step
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  gtg_pkg::t_cell i_d,
    output gtg_pkg::t_cell o_q
);
    import gtg_pkg::*;

    t_cell n_q;
    t_cell r_q;

    always_comb begin
        logic [SQW-1:0] trial;
        trial = '0;
        n_q = i_d;
        if (CORDIC_IDX >= 0) begin
            if (i_d.y >= 0) begin
                n_q.x = i_d.x + (i_d.y >>> CORDIC_IDX);
                n_q.y = i_d.y - (i_d.x >>> CORDIC_IDX);
                n_q.z = i_d.z + atan_entry(CORDIC_IDX);
            end else begin
                n_q.x = i_d.x - (i_d.y >>> CORDIC_IDX);
                n_q.y = i_d.y + (i_d.x >>> CORDIC_IDX);
                n_q.z = i_d.z - atan_entry(CORDIC_IDX);
            end
        end
        if (SQRT_IDX >= 0) begin
            // restoring root, one result bit per cell, msb first
            trial = (SQW'(i_d.root) << (SQRT_IDX + 1)) | (SQW'(1) << (2 * SQRT_IDX));
            if (i_d.rem >= trial) begin
                n_q.rem  = i_d.rem - trial;
                n_q.root = i_d.root | (RTW'(1) << SQRT_IDX);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

### src/go_to_goal_velocity_controller_top.sv
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller_top
// pose to velocity commands through a chain of cordic and square root cells
// ----------------------------------------------------------------------------
// throughput: one request per cycle; the chain advances whenever the output
// register is free or being taken
// reset: gains and limits return to defaults, all valid flags clear
module go_to_goal_velocity_controller_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // target_x[15:0], target_y[31:16], robot_x[47:32], robot_y[63:48],
    // robot_heading[78:64], zero[79]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // linear_velocity[14:0], angular_velocity[30:15], zero[31]
    output logic [31:0] m_axis_tdata
);
    import gtg_pkg::*;

    localparam int NCOR  = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int NCELL = (NCOR > SQRT_STEPS) ? NCOR : SQRT_STEPS;

    logic [11:0] r_lin_gain, r_ang_gain;
    logic [14:0] r_max_lin, r_max_ang, r_stop;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_gain <= 12'd384;
            r_ang_gain <= 12'd1536;
            r_max_lin  <= 15'd901;
            r_max_ang  <= 15'd11633;
            r_stop     <= 15'd1024;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_LIN_GAIN: r_lin_gain <= pwdata[11:0];
                REG_ANG_GAIN: r_ang_gain <= pwdata[11:0];
                REG_MAX_LIN:  r_max_lin  <= pwdata[14:0];
                REG_MAX_ANG:  r_max_ang  <= pwdata[14:0];
                REG_STOP:     r_stop     <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LIN_GAIN: prdata = {20'd0, r_lin_gain};
            REG_ANG_GAIN: prdata = {20'd0, r_ang_gain};
            REG_MAX_LIN:  prdata = {17'd0, r_max_lin};
            REG_MAX_ANG:  prdata = {17'd0, r_max_ang};
            REG_STOP:     prdata = {17'd0, r_stop};
            default:      prdata = '0;
        endcase
    end

    // pipeline: stage 0 (diff/square), cells, stage A (round/mul), stage B (clamp/out)
    localparam int NV = NCELL + 3;
    logic [NV-1:0] r_vld;
    logic          adv;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = r_vld[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NV-2:0], s_axis_tvalid};
        end
    end

    // stage 0: differences, squares, quadrant pre-rotation
    logic signed [16:0] dx, dy;
    logic signed [XW-1:0] xs, ys;
    t_cell n_c0, r_c0;

    assign dx = 17'(signed'(s_axis_tdata[15:0])) - 17'(signed'(s_axis_tdata[47:32]));
    assign dy = 17'(signed'(s_axis_tdata[31:16])) - 17'(signed'(s_axis_tdata[63:48]));
    assign xs = XW'(dx) <<< 14;
    assign ys = XW'(dy) <<< 14;

    always_comb begin
        n_c0.rem  = SQW'(unsigned'(34'(dx * dx))) + SQW'(unsigned'(34'(dy * dy)));
        n_c0.root = '0;
        n_c0.hd   = signed'(s_axis_tdata[78:64]);
        n_c0.zero = (dx == 0) && (dy == 0);
        n_c0.x    = xs;
        n_c0.y    = ys;
        n_c0.z    = '0;
        if (dx < 0) begin
            if (dy >= 0) begin
                n_c0.x = ys;
                n_c0.y = -xs;
                n_c0.z = HALF_PI;
            end else begin
                n_c0.x = -ys;
                n_c0.y = xs;
                n_c0.z = -HALF_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c0 <= n_c0;
        end
    end

    t_cell chain [NCELL+1];
    assign chain[0] = r_c0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        gtg_cell #(
            .CORDIC_IDX ((g < NCOR) ? g : -1),
            .SQRT_IDX   ((g < SQRT_STEPS) ? (SQRT_STEPS - 1 - g) : -1)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_d   (chain[g]),
            .o_q   (chain[g+1])
        );
    end

    // stage A: bearing rounding, distance saturation, gain products
    t_cell                last;
    logic signed [ZW-1:0] zr;
    logic signed [14:0]   brg;
    logic signed [16:0]   err;
    logic [15:0]          dist_sat;
    logic [27:0]          r_lin_p;
    logic signed [29:0]   r_ang_p;
    logic                 r_below;

    assign last     = chain[NCELL];
    assign zr       = last.z + ZW'(131072);
    assign brg      = last.zero ? 15'sd0 : 15'(zr >>> 18);
    assign err      = 17'(brg) - 17'(last.hd);
    assign dist_sat = (last.root > RTW'(16'hFFFF)) ? 16'hFFFF : last.root[15:0];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_below <= ({1'b0, dist_sat} < {2'b0, r_stop});
            r_lin_p <= 28'(r_lin_gain) * 28'(dist_sat);
            r_ang_p <= err * signed'({1'b0, r_ang_gain});
        end
    end

    // stage B: shift and clamp
    logic [19:0]        lin_s;
    logic signed [21:0] w_s;
    logic [14:0]        lin;
    logic signed [15:0] w;
    logic signed [21:0] lim;
    logic [30:0]        r_out;

    assign lin_s = r_lin_p[27:8];
    assign w_s   = r_ang_p[29:8];
    assign lim   = 22'(signed'({1'b0, r_max_ang}));

    always_comb begin
        if (r_below) begin
            lin = '0;
        end else if (lin_s > 20'(r_max_lin)) begin
            lin = r_max_lin;
        end else begin
            lin = lin_s[14:0];
        end
        priority if (w_s > lim) begin
            w = lim[15:0];
        end else if (w_s < -lim) begin
            w = 16'(-lim);
        end else begin
            w = w_s[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= {w, lin};
        end
    end

    assign m_axis_tdata = {1'b0, r_out};

endmodule
